>>> hw/rtl/thrust_to_motor_duty_unit_assert.svh
// ----------------------------------------------------------------------------
// Thrust to motor duty assertion macros
// Shared property forms for the duty unit checks.
// ----------------------------------------------------------------------------
`ifndef THRUST_TO_MOTOR_DUTY_UNIT_ASSERT_SVH
`define THRUST_TO_MOTOR_DUTY_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define TMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define TMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tmd_pkg.sv
// ----------------------------------------------------------------------------
// Thrust to motor duty package
// Widths, step counts, register codes and shared structs.
// ----------------------------------------------------------------------------
package tmd_pkg;

  localparam int NMOTORS   = 4;
  localparam int REG_W     = 63;
  localparam int THRUST_W  = 64;
  localparam int DUTY_W    = 17;
  localparam int QUO_W     = DUTY_W - 1;
  localparam int CFG_IDX_W = 3;
  localparam int LIMB_W    = 32;
  localparam int FRAC_W    = 40;

  // omega search: quotient t*2^80/Ct, root and sqrt remainder
  localparam int Q_W       = 144;
  localparam int ROOT_W    = Q_W / 2;
  localparam int SQREM_W   = ROOT_W + 2;

  // config products and numerator
  localparam int COEF_W    = 2 * REG_W;
  localparam int PROD_W    = 128;
  localparam int ACC_W     = 272;
  localparam int NSHIFT    = 64;
  localparam int NQ_W      = ACC_W - NSHIFT;
  localparam int DREM_W    = COEF_W + QUO_W;
  localparam int DDIV_W    = COEF_W + QUO_W - 1;
  localparam int WV_W      = 5 * LIMB_W;

  // per-phase step counts
  localparam int A_STEPS   = Q_W / 2;
  localparam int B_STEPS   = ROOT_W / 2;
  localparam int C_PP      = 32;
  localparam int C_STEPS   = C_PP + 1;
  localparam int D_STEPS   = QUO_W;
  localparam int COEF_PP   = 20;

  localparam logic [DUTY_W-1:0] FULL_DUTY = 17'h10000;
  localparam logic [REG_W-1:0]  ONE_Q40   = 63'h100_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRUST_COEFF = 3'd0,
    REG_VISC_DAMP    = 3'd1,
    REG_MOTOR_CONST  = 3'd2,
    REG_WIND_RES     = 3'd3,
    REG_DRAG_COEFF   = 3'd4,
    REG_FRICTION     = 3'd5,
    REG_BATTERY      = 3'd6
  } tmd_reg_t;

  typedef enum logic [2:0] {
    JOB_RD  = 3'd0,
    JOB_KK  = 3'd1,
    JOB_RCQ = 3'd2,
    JOB_RQ  = 3'd3,
    JOB_KB  = 3'd4
  } tmd_job_t;

  typedef struct packed {
    logic [REG_W-1:0] ct;
    logic [REG_W-1:0] d;
    logic [REG_W-1:0] k;
    logic [REG_W-1:0] r;
    logic [REG_W-1:0] cq;
    logic [REG_W-1:0] q;
    logic [REG_W-1:0] b;
  } tmd_cfg_t;

  // a1 = R*D + K*K, a2 = R*Cq, a0 = R*Q, kb = K*B
  typedef struct packed {
    logic [PROD_W-1:0] a1;
    logic [PROD_W-1:0] a2;
    logic [PROD_W-1:0] a0;
    logic [PROD_W-1:0] kb;
    logic [REG_W-1:0]  ct;
    logic              zero_div;
  } tmd_coef_t;

  typedef struct packed {
    logic       a_load;
    logic       a_step;
    logic       b_load;
    logic       b_step;
    logic       c_load;
    logic       c_issue;
    logic       c_acc;
    logic       c_term;
    logic [2:0] c_wi;
    logic [1:0] c_aj;
    logic       d_load;
    logic       d_step;
    logic       o_load;
  } tmd_ctl_t;

endpackage

>>> hw/rtl/tmd_coef.sv
// ----------------------------------------------------------------------------
// Coefficient unit
// Forms the config products R*D+K*K, R*Cq, R*Q and K*B on one 32x32 multiplier.
// ----------------------------------------------------------------------------
module tmd_coef (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  tmd_pkg::tmd_cfg_t   cfg,
  output tmd_pkg::tmd_coef_t  coef,
  output logic                ready
);
  import tmd_pkg::*;

  logic [4:0]        cnt_r;
  logic              busy_r;
  logic              ppv_r;
  logic [63:0]       pp_r;
  logic [1:0]        sh_r;
  tmd_job_t          job_r;
  logic [PROD_W-1:0] a1_r, a2_r, a0_r, kb_r;

  logic              issue;
  logic              restart;
  tmd_job_t          job;
  logic [REG_W-1:0]  opa, opb;
  logic [63:0]       opa_x, opb_x;
  logic [LIMB_W-1:0] la, lb;
  logic [PROD_W-1:0] term;

  assign restart = !rst_n || cfg_we;
  assign issue   = busy_r && (cnt_r != 5'(COEF_PP));
  assign job     = tmd_job_t'(cnt_r[4:2]);

  // operand pair for the current product
  always_comb begin
    case (job)
      JOB_RD:  begin opa = cfg.r; opb = cfg.d;  end
      JOB_KK:  begin opa = cfg.k; opb = cfg.k;  end
      JOB_RCQ: begin opa = cfg.r; opb = cfg.cq; end
      JOB_RQ:  begin opa = cfg.r; opb = cfg.q;  end
      JOB_KB:  begin opa = cfg.k; opb = cfg.b;  end
      default: begin opa = '0;    opb = '0;     end
    endcase
    opa_x = {1'b0, opa};
    opb_x = {1'b0, opb};
    la    = opa_x[{cnt_r[1], 5'b0} +: LIMB_W];
    lb    = opb_x[{cnt_r[0], 5'b0} +: LIMB_W];
  end

  assign term = PROD_W'(pp_r) << {sh_r, 5'b0};

  // sequence control
  always_ff @(posedge clk) begin
    if (restart) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      ppv_r  <= 1'b0;
    end else begin
      ppv_r <= issue;
      if (issue) begin
        cnt_r <= cnt_r + 5'd1;
      end else if (busy_r && !ppv_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  // partial product stage
  always_ff @(posedge clk) begin
    pp_r  <= 64'(la) * 64'(lb);
    sh_r  <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
    job_r <= job;
  end

  // accumulate into the matching product
  always_ff @(posedge clk) begin
    if (restart) begin
      a1_r <= '0;
      a2_r <= '0;
      a0_r <= '0;
      kb_r <= '0;
    end else if (ppv_r) begin
      case (job_r)
        JOB_RD, JOB_KK: a1_r <= a1_r + term;
        JOB_RCQ:        a2_r <= a2_r + term;
        JOB_RQ:         a0_r <= a0_r + term;
        JOB_KB:         kb_r <= kb_r + term;
        default:        a1_r <= a1_r;
      endcase
    end
  end

  assign coef.a1       = a1_r;
  assign coef.a2       = a2_r;
  assign coef.a0       = a0_r;
  assign coef.kb       = kb_r;
  assign coef.ct       = cfg.ct;
  assign coef.zero_div = (cfg.ct == '0) || (cfg.k == '0) || (cfg.r == '0) ||
                         (cfg.b == '0);
  assign ready         = !busy_r;

endmodule

>>> hw/rtl/tmd_seq.sv
// ----------------------------------------------------------------------------
// Phase sequencer
// Steps the four lane phases (divide, root, polynomial, duty) and hands beats on.
// ----------------------------------------------------------------------------
module tmd_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               out_free,
  output logic               a_idle,
  output tmd_pkg::tmd_ctl_t  ctl
);
  import tmd_pkg::*;

  logic       a_busy_r, b_busy_r, c_busy_r, d_busy_r;
  logic [6:0] a_cnt_r;
  logic [5:0] b_cnt_r;
  logic [5:0] c_cnt_r;
  logic [4:0] d_cnt_r;
  logic [2:0] c_i_r;
  logic [1:0] c_j_r;
  logic       c_t_r;
  logic       c_acc_r;

  logic a_done, b_done, c_done, d_done;
  logic b_load, c_load, d_load, o_load;
  logic a_step, b_step, c_step, c_issue, d_step;

  assign a_done  = a_busy_r && (a_cnt_r == 7'(A_STEPS));
  assign b_done  = b_busy_r && (b_cnt_r == 6'(B_STEPS));
  assign c_done  = c_busy_r && (c_cnt_r == 6'(C_STEPS));
  assign d_done  = d_busy_r && (d_cnt_r == 5'(D_STEPS));
  assign a_step  = a_busy_r && !a_done;
  assign b_step  = b_busy_r && !b_done;
  assign c_step  = c_busy_r && !c_done;
  assign c_issue = c_busy_r && (c_cnt_r < 6'(C_PP));
  assign d_step  = d_busy_r && !d_done;

  // handoffs between phases
  assign b_load  = a_done && !b_busy_r;
  assign c_load  = b_done && !c_busy_r;
  assign d_load  = c_done && !d_busy_r;
  assign o_load  = d_done && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_busy_r <= 1'b0;
      b_busy_r <= 1'b0;
      c_busy_r <= 1'b0;
      d_busy_r <= 1'b0;
      a_cnt_r  <= '0;
      b_cnt_r  <= '0;
      c_cnt_r  <= '0;
      d_cnt_r  <= '0;
      c_i_r    <= '0;
      c_j_r    <= '0;
      c_t_r    <= 1'b0;
      c_acc_r  <= 1'b0;
    end else begin
      c_acc_r <= c_issue;

      // divide phase
      if (in_fire) begin
        a_busy_r <= 1'b1;
        a_cnt_r  <= '0;
      end else if (b_load) begin
        a_busy_r <= 1'b0;
      end else if (a_step) begin
        a_cnt_r <= a_cnt_r + 7'd1;
      end

      // root phase
      if (b_load) begin
        b_busy_r <= 1'b1;
        b_cnt_r  <= '0;
      end else if (c_load) begin
        b_busy_r <= 1'b0;
      end else if (b_step) begin
        b_cnt_r <= b_cnt_r + 6'd1;
      end

      // polynomial phase, limb walk over W*A1 then W^2*A2
      if (c_load) begin
        c_busy_r <= 1'b1;
        c_cnt_r  <= '0;
        c_i_r    <= '0;
        c_j_r    <= '0;
        c_t_r    <= 1'b0;
      end else if (d_load) begin
        c_busy_r <= 1'b0;
      end else if (c_step) begin
        c_cnt_r <= c_cnt_r + 6'd1;
        if (c_issue) begin
          if (c_j_r == 2'd3) begin
            c_j_r <= '0;
            if (!c_t_r && (c_i_r == 3'd2)) begin
              c_t_r <= 1'b1;
              c_i_r <= '0;
            end else begin
              c_i_r <= c_i_r + 3'd1;
            end
          end else begin
            c_j_r <= c_j_r + 2'd1;
          end
        end
      end

      // duty phase
      if (d_load) begin
        d_busy_r <= 1'b1;
        d_cnt_r  <= '0;
      end else if (o_load) begin
        d_busy_r <= 1'b0;
      end else if (d_step) begin
        d_cnt_r <= d_cnt_r + 5'd1;
      end
    end
  end

  assign a_idle      = !a_busy_r;
  assign ctl.a_load  = in_fire;
  assign ctl.a_step  = a_step;
  assign ctl.b_load  = b_load;
  assign ctl.b_step  = b_step;
  assign ctl.c_load  = c_load;
  assign ctl.c_issue = c_issue;
  assign ctl.c_acc   = c_acc_r;
  assign ctl.c_term  = c_t_r;
  assign ctl.c_wi    = c_i_r;
  assign ctl.c_aj    = c_j_r;
  assign ctl.d_load  = d_load;
  assign ctl.d_step  = d_step;
  assign ctl.o_load  = o_load;

endmodule

>>> hw/rtl/tmd_lane.sv
// ----------------------------------------------------------------------------
// Motor lane
// One thrust to one duty: divide, integer root, numerator MAC, duty divide.
// ----------------------------------------------------------------------------
module tmd_lane (
  input  logic                                  clk,
  input  tmd_pkg::tmd_ctl_t                     ctl,
  input  tmd_pkg::tmd_coef_t                    coef,
  input  logic signed [tmd_pkg::THRUST_W-1:0]   thrust,
  output logic [tmd_pkg::DUTY_W-1:0]            duty
);
  import tmd_pkg::*;

  // divide phase: Q = t * 2^80 / Ct
  logic [Q_W-1:0]      a_sr_r;
  logic [REG_W-1:0]    a_rem_r;
  logic                a_nz_r;
  // root phase: W = isqrt(Q)
  logic [Q_W-1:0]      b_q_r;
  logic [Q_W-1:0]      b_sr_r;
  logic [SQREM_W-1:0]  b_rem_r;
  logic [ROOT_W-1:0]   b_root_r;
  logic                b_nz_r;
  // polynomial phase
  logic [ROOT_W-1:0]   c_w_r;
  logic [Q_W-1:0]      c_w2_r;
  logic [ACC_W-1:0]    c_acc_r;
  logic [63:0]         c_pp_r;
  logic [8:0]          c_sh_r;
  logic                c_nz_r;
  // duty phase
  logic [DREM_W-1:0]   d_rem_r;
  logic [DDIV_W-1:0]   d_div_r;
  logic [QUO_W-1:0]    d_q_r;
  logic                d_sat_r;
  logic                d_nz_r;

  logic [REG_W:0]      a_ct, a_r1, a_s1, a_r2, a_s2;
  logic                a_ge1, a_ge2;
  logic [SQREM_W+1:0]  b_m1, b_t1, b_d1, b_m2, b_t2, b_d2;
  logic [SQREM_W-1:0]  b_rem1;
  logic [ROOT_W-1:0]   b_root1;
  logic                b_ge1, b_ge2;
  logic [WV_W-1:0]     c_wv;
  logic [PROD_W-1:0]   c_av;
  logic [LIMB_W-1:0]   c_wl, c_al;
  logic [2:0]          c_ij;
  logic [8:0]          c_sh;
  logic [NQ_W-1:0]     d_np, d_lim;
  logic                d_ge;

  // two restoring divide steps per cycle
  always_comb begin
    a_ct  = {1'b0, coef.ct};
    a_r1  = {a_rem_r, a_sr_r[Q_W-1]};
    a_ge1 = a_r1 >= a_ct;
    a_s1  = a_ge1 ? a_r1 - a_ct : a_r1;
    a_r2  = {a_s1[REG_W-1:0], a_sr_r[Q_W-2]};
    a_ge2 = a_r2 >= a_ct;
    a_s2  = a_ge2 ? a_r2 - a_ct : a_r2;
  end

  // two root digits per cycle
  always_comb begin
    b_m1    = {b_rem_r, b_sr_r[Q_W-1:Q_W-2]};
    b_t1    = {2'b00, b_root_r, 2'b01};
    b_ge1   = b_m1 >= b_t1;
    b_d1    = b_ge1 ? b_m1 - b_t1 : b_m1;
    b_rem1  = b_d1[SQREM_W-1:0];
    b_root1 = {b_root_r[ROOT_W-2:0], b_ge1};
    b_m2    = {b_rem1, b_sr_r[Q_W-3:Q_W-4]};
    b_t2    = {2'b00, b_root1, 2'b01};
    b_ge2   = b_m2 >= b_t2;
    b_d2    = b_ge2 ? b_m2 - b_t2 : b_m2;
  end

  // limb select for the numerator MAC
  always_comb begin
    c_wv = ctl.c_term ? {(WV_W-Q_W)'(0), c_w2_r} : {(WV_W-ROOT_W)'(0), c_w_r};
    c_av = ctl.c_term ? coef.a2 : coef.a1;
    c_wl = c_wv[{ctl.c_wi, 5'b0} +: LIMB_W];
    c_al = c_av[{ctl.c_aj, 5'b0} +: LIMB_W];
    c_ij = ctl.c_wi + {1'b0, ctl.c_aj};
    c_sh = {1'b0, c_ij, 5'b0} + (ctl.c_term ? 9'd0 : 9'(FRAC_W));
  end

  // duty divide: N / (K*B*2^64), saturation and step compare
  always_comb begin
    d_np  = c_acc_r[ACC_W-1:NSHIFT];
    d_lim = {(NQ_W-DREM_W)'(0), coef.kb[COEF_W-1:0], QUO_W'(0)};
    d_ge  = d_rem_r >= {1'b0, d_div_r};
  end

  always_ff @(posedge clk) begin
    if (ctl.a_load) begin
      a_sr_r  <= {1'b0, thrust[THRUST_W-2:0], 80'b0};
      a_rem_r <= '0;
      a_nz_r  <= thrust[THRUST_W-1] || (thrust == '0);
    end else if (ctl.a_step) begin
      a_sr_r  <= {a_sr_r[Q_W-3:0], a_ge1, a_ge2};
      a_rem_r <= a_s2[REG_W-1:0];
    end

    if (ctl.b_load) begin
      b_q_r    <= a_sr_r;
      b_sr_r   <= a_sr_r;
      b_rem_r  <= '0;
      b_root_r <= '0;
      b_nz_r   <= a_nz_r;
    end else if (ctl.b_step) begin
      b_sr_r   <= {b_sr_r[Q_W-5:0], 4'b0};
      b_rem_r  <= b_d2[SQREM_W-1:0];
      b_root_r <= {b_root1[ROOT_W-2:0], b_ge2};
    end

    // W^2 is Q minus the final root remainder
    if (ctl.c_load) begin
      c_w_r   <= b_root_r;
      c_w2_r  <= b_q_r - {(Q_W-SQREM_W)'(0), b_rem_r};
      c_acc_r <= {(ACC_W-COEF_W-2*FRAC_W)'(0), coef.a0[COEF_W-1:0], (2*FRAC_W)'(0)};
      c_nz_r  <= b_nz_r;
    end else if (ctl.c_acc) begin
      c_acc_r <= c_acc_r + (ACC_W'(c_pp_r) << c_sh_r);
    end
    if (ctl.c_issue) begin
      c_pp_r <= 64'(c_wl) * 64'(c_al);
      c_sh_r <= c_sh;
    end

    if (ctl.d_load) begin
      d_sat_r <= d_np >= d_lim;
      d_rem_r <= d_np[DREM_W-1:0];
      d_div_r <= {coef.kb[COEF_W-1:0], (QUO_W-1)'(0)};
      d_q_r   <= '0;
      d_nz_r  <= c_nz_r;
    end else if (ctl.d_step) begin
      d_rem_r <= d_ge ? d_rem_r - {1'b0, d_div_r} : d_rem_r;
      d_q_r   <= {d_q_r[QUO_W-2:0], d_ge};
      d_div_r <= d_div_r >> 1;
    end
  end

  // special cases: zero or negative thrust gives zero, a zero divisor or overrange gives full
  always_comb begin
    if (d_nz_r) begin
      duty = '0;
    end else if (coef.zero_div || d_sat_r) begin
      duty = FULL_DUTY;
    end else begin
      duty = {1'b0, d_q_r};
    end
  end

endmodule

>>> hw/rtl/thrust_to_motor_duty_unit.sv
// ----------------------------------------------------------------------------
// Thrust to motor duty unit
// Maps four signed Q24.40 rotor thrusts to Q1.16 PWM duties per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries four thrusts per beat; the output
//   channel out_valid/out_ready carries the four duties for that beat.
//   Four lanes run in lockstep; each lane walks a bit-serial divider
//   (t*2^80/Ct, 2 bits a cycle), a 2-bit-a-cycle integer root, a 32x32 MAC
//   over 32 limb products and a 16-step duty divider.
//   A beat passes the divider, root, MAC and duty phases in order and then
//   the output register before out_valid rises. The divider phase sets the
//   rate: a new beat is taken as soon as the divider is free, while the later
//   phases and the output register still hold earlier beats. Config writes
//   (cfg_we, cfg_idx, cfg_wdata) take effect at once; the coefficient unit
//   then rebuilds its products with in_ready low. After reset the registers
//   hold their defaults and the same rebuild runs before the first beat is taken.
//   When the receiver stalls, the duty phase holds its result, the earlier
//   phases fill behind it and in_ready drops once the divider is occupied.
// ----------------------------------------------------------------------------
`include "thrust_to_motor_duty_unit_assert.svh"

module thrust_to_motor_duty_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tmd_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [tmd_pkg::REG_W-1:0]            cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [tmd_pkg::THRUST_W-1:0]  in_thrust_m0,
  input  logic signed [tmd_pkg::THRUST_W-1:0]  in_thrust_m1,
  input  logic signed [tmd_pkg::THRUST_W-1:0]  in_thrust_m2,
  input  logic signed [tmd_pkg::THRUST_W-1:0]  in_thrust_m3,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tmd_pkg::DUTY_W-1:0]           out_duty_m0,
  output logic [tmd_pkg::DUTY_W-1:0]           out_duty_m1,
  output logic [tmd_pkg::DUTY_W-1:0]           out_duty_m2,
  output logic [tmd_pkg::DUTY_W-1:0]           out_duty_m3
);
  import tmd_pkg::*;

  tmd_cfg_t                 cfg_r;
  tmd_coef_t                coef;
  tmd_ctl_t                 ctl;
  logic                     coef_ready;
  logic                     a_idle;
  logic                     in_fire;
  logic                     out_free;
  logic                     out_valid_r;
  logic                     duty_in_range;
  logic signed [THRUST_W-1:0] thrust [NMOTORS];
  logic [DUTY_W-1:0]        lane_duty [NMOTORS];
  logic [DUTY_W-1:0]        out_duty_r [NMOTORS];

  assign in_ready = a_idle && coef_ready;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ct <= ONE_Q40;
      cfg_r.d  <= '0;
      cfg_r.k  <= ONE_Q40;
      cfg_r.r  <= ONE_Q40;
      cfg_r.cq <= '0;
      cfg_r.q  <= '0;
      cfg_r.b  <= ONE_Q40;
    end else if (cfg_we) begin
      case (tmd_reg_t'(cfg_idx))
        REG_THRUST_COEFF: cfg_r.ct <= cfg_wdata;
        REG_VISC_DAMP:    cfg_r.d  <= cfg_wdata;
        REG_MOTOR_CONST:  cfg_r.k  <= cfg_wdata;
        REG_WIND_RES:     cfg_r.r  <= cfg_wdata;
        REG_DRAG_COEFF:   cfg_r.cq <= cfg_wdata;
        REG_FRICTION:     cfg_r.q  <= cfg_wdata;
        REG_BATTERY:      cfg_r.b  <= cfg_wdata;
        default:          cfg_r    <= cfg_r;
      endcase
    end
  end

  tmd_coef u_coef (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_we (cfg_we),
    .cfg    (cfg_r),
    .coef   (coef),
    .ready  (coef_ready)
  );

  tmd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .a_idle   (a_idle),
    .ctl      (ctl)
  );

  assign thrust[0] = in_thrust_m0;
  assign thrust[1] = in_thrust_m1;
  assign thrust[2] = in_thrust_m2;
  assign thrust[3] = in_thrust_m3;

  for (genvar g = 0; g < NMOTORS; g++) begin : g_lane
    tmd_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .coef   (coef),
      .thrust (thrust[g]),
      .duty   (lane_duty[g])
    );
  end

  // merge lanes into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.o_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.o_load) begin
      out_duty_r <= lane_duty;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_duty_m0 = out_duty_r[0];
  assign out_duty_m1 = out_duty_r[1];
  assign out_duty_m2 = out_duty_r[2];
  assign out_duty_m3 = out_duty_r[3];

  // checks
  assign duty_in_range = (out_duty_m0 <= FULL_DUTY) && (out_duty_m1 <= FULL_DUTY) &&
                         (out_duty_m2 <= FULL_DUTY) && (out_duty_m3 <= FULL_DUTY);

  `TMD_ASSERT_NEXT(a_accept_blocks, in_valid && in_ready, !in_ready, "divider took two beats")
  `TMD_ASSERT_NEXT(a_cfg_rebuild, cfg_we, !in_ready, "beat taken during coefficient rebuild")
  `TMD_ASSERT_NOW(a_duty_range, out_valid, duty_in_range, "duty above full scale")

endmodule

>>> dv/thrust_to_motor_duty_unit_test.sv
// ----------------------------------------------------------------------------
// Thrust to motor duty unit testbench
// Drives thrust beats under several coefficient settings and flow-control
// mixes, predicts each duty with exact wide integer math, and checks every
// output beat in order.
// ----------------------------------------------------------------------------
module thrust_to_motor_duty_unit_test;
  import tmd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [REG_W-1:0]     REG_MAX    = {REG_W{1'b1}};
  localparam int                   LONG_HOLD  = 700;

  typedef struct packed {
    logic signed [THRUST_W-1:0] t0, t1, t2, t3;
  } thrust_beat_t;

  typedef struct packed {
    logic [DUTY_W-1:0] d0, d1, d2, d3;
  } duty_beat_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [REG_W-1:0] cfg_wdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [THRUST_W-1:0] in_thrust_m0, in_thrust_m1, in_thrust_m2, in_thrust_m3;
  logic [DUTY_W-1:0] out_duty_m0, out_duty_m1, out_duty_m2, out_duty_m3;

  thrust_beat_t pending_thrusts[$];
  duty_beat_t   expected_duties[$];
  tmd_cfg_t     coef_shadow;
  int           send_idle_pct, recv_stall_pct;
  logic         long_hold_req, long_hold_done;
  int           long_hold_cnt;
  int           fail_cnt = 0;

  thrust_to_motor_duty_unit dut (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Exact duty for one thrust under the current coefficients
  function automatic logic [DUTY_W-1:0] motor_duty(logic signed [THRUST_W-1:0] thr);
    logic [319:0] lim, w, cand, ct, d, k, r, cq, q, b, f, num, den, quo;
    if (thr <= 0) return '0;
    if (coef_shadow.ct == 0 || coef_shadow.k == 0 || coef_shadow.r == 0 ||
        coef_shadow.b == 0) return FULL_DUTY;
    ct = coef_shadow.ct; d = coef_shadow.d; k = coef_shadow.k; r = coef_shadow.r;
    cq = coef_shadow.cq; q = coef_shadow.q; b = coef_shadow.b;
    f = 320'd1 << FRAC_W;
    lim = 320'($unsigned(thr)) << 80;
    // omega: largest root with w^2 * ct <= t * 2^80
    w = '0;
    for (int i = 71; i >= 0; i--) begin
      cand = w | (320'd1 << i);
      if (cand * cand * ct <= lim) w = cand;
    end
    num = f * w * (r * d + k * k) + r * cq * w * w + r * q * f * f;
    den = (k * b) << 64;
    quo = num / den;
    return (quo >= 320'd65536) ? FULL_DUTY : quo[DUTY_W-1:0];
  endfunction

  // Driver: offers queued beats, records expected duties on acceptance
  always @(posedge clk) begin
    duty_beat_t e;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        e.d0 = motor_duty(in_thrust_m0);
        e.d1 = motor_duty(in_thrust_m1);
        e.d2 = motor_duty(in_thrust_m2);
        e.d3 = motor_duty(in_thrust_m3);
        expected_duties.push_back(e);
      end
      if (pending_thrusts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        thrust_beat_t t;
        t = pending_thrusts.pop_front();
        in_valid     <= 1'b1;
        in_thrust_m0 <= t.t0;
        in_thrust_m1 <= t.t1;
        in_thrust_m2 <= t.t2;
        in_thrust_m3 <= t.t3;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold, counted in cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      long_hold_cnt  <= 0;
      long_hold_done <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_cnt  <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (long_hold_cnt > 0) begin
      long_hold_cnt <= long_hold_cnt - 1;
    end
  end

  // Monitor: checks each output beat, drives random and long stalls
  always @(posedge clk) begin
    duty_beat_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_duties.size() == 0) begin
          $error("unexpected duty beat");
          fail_cnt++;
        end else begin
          e = expected_duties.pop_front();
          if (out_duty_m0 !== e.d0) begin
            $error("duty_m0 exp %0d got %0d", e.d0, out_duty_m0); fail_cnt++;
          end
          if (out_duty_m1 !== e.d1) begin
            $error("duty_m1 exp %0d got %0d", e.d1, out_duty_m1); fail_cnt++;
          end
          if (out_duty_m2 !== e.d2) begin
            $error("duty_m2 exp %0d got %0d", e.d2, out_duty_m2); fail_cnt++;
          end
          if (out_duty_m3 !== e.d3) begin
            $error("duty_m3 exp %0d got %0d", e.d3, out_duty_m3); fail_cnt++;
          end
        end
      end
      if ((long_hold_req && !long_hold_done) || long_hold_cnt > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic signed [THRUST_W-1:0] rand_thrust();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       return v;                                  // any value, sign included
      1:       return -$signed(v >> $urandom_range(63));  // mostly nonpositive
      2:       return '0;
      default: return v >> $urandom_range(63, 20);        // mostly mid-range duties
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_THRUST_COEFF: coef_shadow.ct = val;
      REG_VISC_DAMP:    coef_shadow.d  = val;
      REG_MOTOR_CONST:  coef_shadow.k  = val;
      REG_WIND_RES:     coef_shadow.r  = val;
      REG_DRAG_COEFF:   coef_shadow.cq = val;
      REG_FRICTION:     coef_shadow.q  = val;
      REG_BATTERY:      coef_shadow.b  = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_thrusts.size() > 0 || in_valid || expected_duties.size() > 0)
      @(posedge clk);
  endtask

  task automatic queue_random(int cnt);
    thrust_beat_t t;
    repeat (cnt) begin
      t.t0 = rand_thrust(); t.t1 = rand_thrust();
      t.t2 = rand_thrust(); t.t3 = rand_thrust();
      pending_thrusts.push_back(t);
    end
  endtask

  function automatic logic [REG_W-1:0] rand_reg();
    return REG_W'({$urandom, $urandom}) >> $urandom_range(62, 10);
  endfunction

  // Timeout
  initial begin
    #8000000;
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus sequence
  initial begin
    thrust_beat_t t;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    long_hold_req = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    coef_shadow = '{ct: ONE_Q40, d: '0, k: ONE_Q40, r: ONE_Q40, cq: '0, q: '0, b: ONE_Q40};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes and special cases under defaults
    t = '{t0: 64'sd0, t1: 64'sd1, t2: -64'sd1, t3: 64'sh7FFF_FFFF_FFFF_FFFF};
    pending_thrusts.push_back(t);
    t = '{t0: 64'sh8000_0000_0000_0000, t1: 64'sd1 << 40, t2: 64'sd1 << 20,
          t3: 64'sd1 << 8};
    pending_thrusts.push_back(t);
    t = '{t0: 64'sh5555_5555_5555_5555, t1: 64'shAAAA_AAAA_AAAA_AAAA,
          t2: 64'sh0000_0000_3333_3333, t3: 64'sh0000_00FF_FFFF_FFFF};
    pending_thrusts.push_back(t);
    wait_drained();

    // Realistic motor: mid duties, friction and drag active, ignored index
    write_reg(REG_THRUST_COEFF, 63'd1 << 30);
    write_reg(REG_VISC_DAMP, 63'd1 << 20);
    write_reg(REG_MOTOR_CONST, 63'd1 << 34);
    write_reg(REG_WIND_RES, 63'd1 << 37);
    write_reg(REG_DRAG_COEFF, 63'd1 << 16);
    write_reg(REG_FRICTION, 63'd1 << 28);
    write_reg(REG_BATTERY, 63'd12 << 40);
    write_reg(REG_UNUSED, REG_MAX);
    queue_random(10);
    wait_drained();

    // Zero divisors, one at a time
    write_reg(REG_BATTERY, '0);
    queue_random(3);
    wait_drained();
    write_reg(REG_BATTERY, 63'd12 << 40);
    write_reg(REG_THRUST_COEFF, '0);
    queue_random(3);
    wait_drained();
    write_reg(REG_THRUST_COEFF, REG_MAX);
    write_reg(REG_MOTOR_CONST, '0);
    queue_random(2);
    wait_drained();
    write_reg(REG_MOTOR_CONST, REG_MAX);
    write_reg(REG_WIND_RES, '0);
    queue_random(2);
    wait_drained();

    // All registers at maximum
    for (int i = 0; i < 7; i++) write_reg(tmd_reg_t'(i), REG_MAX);
    queue_random(4);
    wait_drained();

    // Random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 7; i++) write_reg(tmd_reg_t'(i), rand_reg());
      @(posedge clk);
      case (ph % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 79; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 79; end
        default: begin send_idle_pct <= 11; recv_stall_pct <= 11; end
      endcase
      if (ph == 4) long_hold_req <= 1'b1;  // receiver holds off, input backs up
      queue_random(85);
      wait_drained();  // sender pauses until every duty is back
    end

    repeat (300) @(posedge clk);
    if (fail_cnt == 0 && expected_duties.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/tmd_pkg.sv
hw/rtl/tmd_coef.sv
hw/rtl/tmd_seq.sv
hw/rtl/tmd_lane.sv
hw/rtl/thrust_to_motor_duty_unit.sv
dv/thrust_to_motor_duty_unit_test.sv
